// ----- rtl/dcrc_pkg.sv -----
// Shared types and constants for the digit-coded radix converter.
package dcrc_pkg;

   // operand and result width, stream data width, BCD digits of a full operand
   localparam int OPERAND_W  = 60;
   localparam int TDATA_W    = 64;
   localparam int BCD_DIGITS = 19;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int CNT_W      = $clog2(OPERAND_W + 1);
   localparam int STEP_W     = $clog2(OPERAND_W);

   // conversion selector codes
   localparam logic [1:0] MODE_BIN2VAL = 2'd0;
   localparam logic [1:0] MODE_VAL2BIN = 2'd1;
   localparam logic [1:0] MODE_VAL2OCT = 2'd2;
   localparam logic [1:0] MODE_OCT2VAL = 2'd3;

   // control from the sequencer to the datapath units
   typedef struct packed {
      logic clear;       // start of a new word
      logic bit_step;    // one operand bit (scan phase)
      logic digit_step;  // one BCD digit (digit phase)
      logic octal;       // radix 8 instead of radix 2
   } dcrc_ctrl_type;

   // 10^n, evaluated at elaboration
   function automatic logic [63:0] pow10(input int n);
      logic [63:0] r;
      r = 64'd1;
      for (int i = 0; i < n; i++) begin
         r = r * 64'd10;
      end
      return r;
   endfunction

endpackage

// ----- rtl/dcrc_dabble.sv -----
// Bit-serial binary to BCD converter (shift-and-add-3) with digit shift-out.
module dcrc_dabble (
   input  logic                    clock,
   input  logic                    reset,
   input  dcrc_pkg::dcrc_ctrl_type ctrl,
   input  logic                    bit_in,
   output logic [3:0]              digit_out
);
   import dcrc_pkg::*;

   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic [BCD_W-1:0] adj;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
         adj[4*d +: 4] = (bcd_ff[4*d +: 4] >= 4'd5) ? bcd_ff[4*d +: 4] + 4'd3
                                                     : bcd_ff[4*d +: 4];
      end
   end

   // clear, shift in a bit, or shift out the top digit
   always_comb begin
      bcd_in = bcd_ff;
      if (ctrl.clear) begin
         bcd_in = '0;
      end else if (ctrl.bit_step) begin
         bcd_in = {adj[BCD_W-2:0], bit_in};
      end else if (ctrl.digit_step) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'b0000};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcd_ff <= '0;
      end else begin
         bcd_ff <= bcd_in;
      end
   end

   assign digit_out = bcd_ff[BCD_W-1 -: 4];

endmodule

// ----- rtl/dcrc_horner.sv -----
// Horner accumulator: times 10 per coded digit, or times radix per BCD digit.
module dcrc_horner (
   input  logic                          clock,
   input  logic                          reset,
   input  dcrc_pkg::dcrc_ctrl_type       ctrl,
   input  logic                          bit_in,
   input  logic [3:0]                    digit_in,
   output logic [dcrc_pkg::OPERAND_W-1:0] acc,
   output logic [dcrc_pkg::CNT_W-1:0]     count
);
   import dcrc_pkg::*;

   logic [OPERAND_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [1:0]           grp_ff, grp_in;    // octal digit being assembled
   logic [1:0]           phase_ff, phase_in;
   logic                 commit;
   logic [3:0]           d;
   logic [OPERAND_W-1:0] scaled;

   // pick the digit and decide whether this cycle folds it in
   always_comb begin
      commit = 1'b0;
      d      = digit_in;
      if (ctrl.bit_step) begin
         if (ctrl.octal) begin
            commit = (phase_ff == 2'd2);
            d      = {1'b0, grp_ff, bit_in};
         end else begin
            commit = 1'b1;
            d      = {3'b000, bit_in};
         end
      end else if (ctrl.digit_step) begin
         commit = 1'b1;
      end
   end

   // scale the accumulator: x10 for coded output, x2 or x8 for coded input
   always_comb begin
      if (ctrl.bit_step) begin
         scaled = (acc_ff << 3) + (acc_ff << 1);
      end else if (ctrl.octal) begin
         scaled = acc_ff << 3;
      end else begin
         scaled = acc_ff << 1;
      end
   end

   always_comb begin
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      grp_in   = grp_ff;
      phase_in = phase_ff;
      if (ctrl.clear) begin
         acc_in   = '0;
         cnt_in   = '0;
         grp_in   = '0;
         phase_in = '0;
      end else begin
         if (ctrl.bit_step) begin
            grp_in   = {grp_ff[0], bit_in};
            phase_in = (phase_ff == 2'd2) ? 2'd0 : phase_ff + 2'd1;
         end
         if (commit) begin
            acc_in = scaled + {{(OPERAND_W-4){1'b0}}, d};
            // count significant coded digits, from the first nonzero one
            if (ctrl.bit_step && (cnt_ff != '0 || d != 4'd0)) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         cnt_ff   <= '0;
         grp_ff   <= '0;
         phase_ff <= '0;
      end else begin
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         grp_ff   <= grp_in;
         phase_ff <= phase_in;
      end
   end

   assign acc   = acc_ff;
   assign count = cnt_ff;

endmodule

// ----- rtl/digit_coded_radix_converter_top.sv -----
// Top level of the digit-coded radix converter: sequencer and result register.
//
// Converts one word between a plain value and a number whose decimal digits are
// base-2 or base-8 digits. The operand is walked one bit per cycle, MSB first.
// Value to binary or octal coded folds each coded digit into a x10 accumulator
// during that walk. Binary or octal coded to value first turns the operand into
// 19 BCD digits with a bit-serial shift-and-add-3 register, then walks those
// digits one per cycle through a x2 or x8 accumulator. A result of 10^DIGITS or
// more sets the overflow flag and returns zero. The result sits in an output
// register, so the next word is accepted while an earlier result still waits on
// rsp_tready; a finished conversion holds until that register is free.
module digit_coded_radix_converter_top #(
   parameter int DIGITS = 18
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [dcrc_pkg::TDATA_W-1:0] req_tdata,   // [59:0] operand
   input  logic [1:0]                   req_tuser,   // [1:0] req_type
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [dcrc_pkg::TDATA_W-1:0] rsp_tdata,   // [59:0] converted
   output logic [0:0]                   rsp_tuser    // [0] overflow
);
   import dcrc_pkg::*;

   localparam logic [OPERAND_W-1:0] LIMIT = OPERAND_W'(pow10(DIGITS));

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      DIGIT,
      DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [OPERAND_W-1:0]  op_ff, op_in;
   logic [1:0]            mode_ff, mode_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OPERAND_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   dcrc_ctrl_type         ctrl;
   logic                  to_value;
   logic                  accept;
   logic [3:0]            digit;
   logic [OPERAND_W-1:0]  acc;
   logic [CNT_W-1:0]      count;
   logic                  ovf;

   assign accept   = req_tvalid && req_tready;
   assign to_value = (mode_ff == MODE_BIN2VAL) || (mode_ff == MODE_OCT2VAL);

   // datapath control
   always_comb begin
      ctrl.clear      = accept;
      ctrl.bit_step   = (state_ff == SCAN);
      ctrl.digit_step = (state_ff == DIGIT);
      ctrl.octal      = (mode_ff == MODE_VAL2OCT) || (mode_ff == MODE_OCT2VAL);
   end

   dcrc_dabble u_dabble (
      .clock     (clock),
      .reset     (reset),
      .ctrl      ('{clear: ctrl.clear, bit_step: ctrl.bit_step && to_value,
                    digit_step: ctrl.digit_step, octal: ctrl.octal}),
      .bit_in    (op_ff[OPERAND_W-1]),
      .digit_out (digit)
   );

   dcrc_horner u_horner (
      .clock    (clock),
      .reset    (reset),
      .ctrl     ('{clear: ctrl.clear, bit_step: ctrl.bit_step && !to_value,
                   digit_step: ctrl.digit_step, octal: ctrl.octal}),
      .bit_in   (op_ff[OPERAND_W-1]),
      .digit_in (digit),
      .acc      (acc),
      .count    (count)
   );

   // overflow: too many coded digits, or a value of 10^DIGITS or more
   assign ovf = to_value ? (acc >= LIMIT) : (count > CNT_W'(DIGITS));

   // sequencer and result register
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      mode_in      = mode_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      case (state_ff)
         IDLE: begin
            if (accept) begin
               op_in    = req_tdata[OPERAND_W-1:0];
               mode_in  = req_tuser;
               step_in  = '0;
               state_in = SCAN;
            end
         end
         SCAN: begin
            op_in   = {op_ff[OPERAND_W-2:0], 1'b0};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(OPERAND_W - 1)) begin
               step_in  = '0;
               state_in = to_value ? DIGIT : DONE;
            end
         end
         DIGIT: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(BCD_DIGITS - 1)) begin
               state_in = DONE;
            end
         end
         DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = ovf ? '0 : acc;
               rsp_ovf_in   = ovf;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      mode_ff     <= mode_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(TDATA_W-OPERAND_W){1'b0}}, rsp_data_ff};
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

// ----- rtl/dcrc_checker.sv -----
// Port-level checks for the digit-coded radix converter, bound to the top level.
module dcrc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [dcrc_pkg::TDATA_W-1:0] rsp_tdata,
   input logic [0:0]                   rsp_tuser
);
   import dcrc_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // overflow always comes with a zero result
   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("overflow with nonzero result");

   // the converter is busy right after taking a word
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted a word while converting");

   // a result never shows up the cycle after a word is taken
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result too early");

endmodule

bind digit_coded_radix_converter_top dcrc_checker u_dcrc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
